[sv/qtcc_pkg.sv]
// Package for the quaternion three-component codec.
// Holds the fixed-point widths, derived constants and the transaction types
// shared by the front pipeline, the square-root cells and the top level.
`default_nettype none

package qtcc_pkg;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    localparam int FRAC_BITS  = 14;
    localparam int CODE_SCALE = 1000;

    localparam int COMP_W = 16;
    localparam int CODE_W = 11;
    localparam int IDX_W  = 2;
    localparam int ABS_W  = COMP_W + 1;

    localparam int SCALE_W = $clog2(CODE_SCALE + 1);

    // Pack path: magnitude times scale, then shift by the fraction bits.
    localparam int QPROD_W = ABS_W + SCALE_W;
    localparam int CSUM_W  = imax(SCALE_W + 1, CODE_W);

    // Unpack path: magnitude times 2^FRAC_BITS / CODE_SCALE by reciprocal.
    localparam int DMAG_W = imax(CODE_W, SCALE_W);
    localparam int RS     = DMAG_W + SCALE_W;
    localparam logic [63:0] RK =
        ((64'd1 << (FRAC_BITS + RS)) + 64'(CODE_SCALE) - 64'd1) / 64'(CODE_SCALE);
    localparam int RK_W    = $clog2(RK + 64'd1);
    localparam int DPROD_W = DMAG_W + RK_W;
    localparam int DQ_W    = DPROD_W - RS;
    localparam int RX_W    = imax(DQ_W, COMP_W) + 1;

    // Sum of squares and radicand.
    localparam int SQ_W  = 2 * ABS_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int RAD_W = 2 * FRAC_BITS + 1;
    localparam int DC_W  = imax(SUM_W, RAD_W);

    // Square-root cell row: one cell per result bit.
    localparam int ROOT_W = FRAC_BITS + 1;
    localparam int NCELL  = ROOT_W;
    localparam int RADP_W = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int RC_W   = imax(ROOT_W, COMP_W);

    localparam logic [DMAG_W-1:0]  SCALE_D   = DMAG_W'(CODE_SCALE);
    localparam logic [QPROD_W-1:0] SCALE_Q   = QPROD_W'(CODE_SCALE);
    localparam logic [CSUM_W-1:0]  SCALE_C   = CSUM_W'(CODE_SCALE);
    localparam logic [DPROD_W-1:0] RK_C      = DPROD_W'(RK);
    localparam logic [RX_W-1:0]    SAT_POS_X = RX_W'((1 << (COMP_W - 1)) - 1);
    localparam logic [RX_W-1:0]    SAT_NEG_X = RX_W'(1 << (COMP_W - 1));
    localparam logic [RC_W-1:0]    SAT_R     = RC_W'((1 << (COMP_W - 1)) - 1);
    localparam logic [DC_W-1:0]    ONE_C     = DC_W'(1) << (2 * FRAC_BITS);
    localparam logic [ROOT_W-1:0]  ROOT_ONE  = ROOT_W'(1) << FRAC_BITS;

    localparam logic ACT_PACK   = 1'b0;
    localparam logic ACT_UNPACK = 1'b1;

    typedef struct packed {
        logic              action;
        logic [CODE_W-1:0] code_a;
        logic [CODE_W-1:0] code_b;
        logic [CODE_W-1:0] code_c;
        logic [IDX_W-1:0]  drop_index;
        logic [COMP_W-1:0] kept_a;
        logic [COMP_W-1:0] kept_b;
        logic [COMP_W-1:0] kept_c;
    } item_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RADP_W-1:0] rad;
    } sqrt_t;

    typedef struct packed {
        item_t item;
        sqrt_t sq;
    } cell_t;

endpackage

`default_nettype wire

[sv/qtcc_prep.sv]
// Front pipeline of the quaternion codec: largest-component search, quantize,
// dequantize, squares and radicand, in six stages with per-stage flow control.
// Depends on qtcc_pkg.
`default_nettype none

module qtcc_prep (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           action,
    input  wire logic [qtcc_pkg::COMP_W-1:0]    quat_x,
    input  wire logic [qtcc_pkg::COMP_W-1:0]    quat_y,
    input  wire logic [qtcc_pkg::COMP_W-1:0]    quat_z,
    input  wire logic [qtcc_pkg::COMP_W-1:0]    quat_w,
    input  wire logic [qtcc_pkg::CODE_W-1:0]    code_a,
    input  wire logic [qtcc_pkg::CODE_W-1:0]    code_b,
    input  wire logic [qtcc_pkg::CODE_W-1:0]    code_c,
    input  wire logic [qtcc_pkg::IDX_W-1:0]     drop_index,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output qtcc_pkg::cell_t                     out_data
);

    logic [5:0] valid_reg;
    logic [5:0] adv;

    logic [qtcc_pkg::COMP_W-1:0] quat_in [4];
    logic [qtcc_pkg::CODE_W-1:0] code_in [3];
    logic [qtcc_pkg::ABS_W-1:0]  ext     [4];
    logic [qtcc_pkg::DMAG_W-1:0] cx      [3];

    // Stage 1
    logic [qtcc_pkg::ABS_W-1:0]  s1_abs_next  [4];
    logic [3:0]                  s1_neg_next;
    logic                        s1_w01_next;
    logic                        s1_w23_next;
    logic [qtcc_pkg::DMAG_W-1:0] s1_dmag_next [3];
    logic [2:0]                  s1_dneg_next;

    logic                        s1_action_reg;
    logic [qtcc_pkg::IDX_W-1:0]  s1_idx_reg;
    logic [qtcc_pkg::ABS_W-1:0]  s1_abs_reg  [4];
    logic [3:0]                  s1_neg_reg;
    logic                        s1_w01_reg;
    logic                        s1_w23_reg;
    logic [qtcc_pkg::DMAG_W-1:0] s1_dmag_reg [3];
    logic [2:0]                  s1_dneg_reg;

    // Stage 2
    logic [qtcc_pkg::ABS_W-1:0]   m01;
    logic [qtcc_pkg::ABS_W-1:0]   m23;
    logic [qtcc_pkg::IDX_W-1:0]   best;
    logic                         s2_flip_next;
    logic [qtcc_pkg::IDX_W-1:0]   s2_idx_next;
    logic [qtcc_pkg::DPROD_W-1:0] s2_dprod_next [3];

    logic                         s2_action_reg;
    logic [qtcc_pkg::IDX_W-1:0]   s2_idx_reg;
    logic [qtcc_pkg::ABS_W-1:0]   s2_abs_reg   [4];
    logic [3:0]                   s2_neg_reg;
    logic                         s2_flip_reg;
    logic [qtcc_pkg::DPROD_W-1:0] s2_dprod_reg [3];
    logic [2:0]                   s2_dneg_reg;

    // Stage 3
    logic [qtcc_pkg::ABS_W-1:0]   sel_abs [3];
    logic [2:0]                   sel_neg;
    logic [qtcc_pkg::RX_W-1:0]    rx      [3];
    logic [qtcc_pkg::RX_W-1:0]    lim     [3];
    logic [qtcc_pkg::RX_W-1:0]    rc      [3];
    logic [qtcc_pkg::RX_W-1:0]    rt      [3];
    logic [qtcc_pkg::QPROD_W-1:0] s3_qprod_next [3];
    logic [2:0]                   s3_qneg_next;
    logic [qtcc_pkg::COMP_W-1:0]  s3_kept_next  [3];

    logic                         s3_action_reg;
    logic [qtcc_pkg::IDX_W-1:0]   s3_idx_reg;
    logic [qtcc_pkg::QPROD_W-1:0] s3_qprod_reg [3];
    logic [2:0]                   s3_qneg_reg;
    logic [qtcc_pkg::COMP_W-1:0]  s3_kept_reg  [3];

    // Stage 4
    logic [qtcc_pkg::QPROD_W-1:0] qs   [3];
    logic [qtcc_pkg::QPROD_W-1:0] qc   [3];
    logic [qtcc_pkg::CSUM_W-1:0]  csum [3];
    logic [qtcc_pkg::ABS_W-1:0]   kext [3];
    logic [qtcc_pkg::ABS_W-1:0]   ka   [3];
    logic [qtcc_pkg::CODE_W-1:0]  s4_code_next [3];
    logic [qtcc_pkg::SQ_W-1:0]    s4_sq_next   [3];

    logic                         s4_action_reg;
    logic [qtcc_pkg::IDX_W-1:0]   s4_idx_reg;
    logic [qtcc_pkg::CODE_W-1:0]  s4_code_reg [3];
    logic [qtcc_pkg::COMP_W-1:0]  s4_kept_reg [3];
    logic [qtcc_pkg::SQ_W-1:0]    s4_sq_reg   [3];

    // Stage 5
    logic [qtcc_pkg::SUM_W-1:0]   s5_sum_next;

    logic                         s5_action_reg;
    logic [qtcc_pkg::IDX_W-1:0]   s5_idx_reg;
    logic [qtcc_pkg::CODE_W-1:0]  s5_code_reg [3];
    logic [qtcc_pkg::COMP_W-1:0]  s5_kept_reg [3];
    logic [qtcc_pkg::SUM_W-1:0]   s5_sum_reg;

    // Stage 6
    logic [qtcc_pkg::DC_W-1:0]    sumx;
    logic [qtcc_pkg::RAD_W-1:0]   s6_diff_next;

    logic                         s6_action_reg;
    logic [qtcc_pkg::IDX_W-1:0]   s6_idx_reg;
    logic [qtcc_pkg::CODE_W-1:0]  s6_code_reg [3];
    logic [qtcc_pkg::COMP_W-1:0]  s6_kept_reg [3];
    logic [qtcc_pkg::RAD_W-1:0]   s6_diff_reg;

    // A stage moves when it is empty or its successor moves.
    always_comb
    begin
        adv[5] = !valid_reg[5] || out_ready;
        for (int k = 4; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < 6; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 1: magnitudes, signs and pairwise winners; code offsets.
    always_comb
    begin
        quat_in[0] = quat_x;
        quat_in[1] = quat_y;
        quat_in[2] = quat_z;
        quat_in[3] = quat_w;
        code_in[0] = code_a;
        code_in[1] = code_b;
        code_in[2] = code_c;
        for (int i = 0; i < 4; i++)
        begin
            ext[i]         = {quat_in[i][qtcc_pkg::COMP_W-1], quat_in[i]};
            s1_neg_next[i] = quat_in[i][qtcc_pkg::COMP_W-1];
            s1_abs_next[i] = s1_neg_next[i] ? (~ext[i] + 1'b1) : ext[i];
        end
        s1_w01_next = s1_abs_next[1] > s1_abs_next[0];
        s1_w23_next = s1_abs_next[3] > s1_abs_next[2];
        for (int j = 0; j < 3; j++)
        begin
            cx[j]           = qtcc_pkg::DMAG_W'(code_in[j]);
            s1_dneg_next[j] = cx[j] < qtcc_pkg::SCALE_D;
            s1_dmag_next[j] = s1_dneg_next[j] ? (qtcc_pkg::SCALE_D - cx[j])
                                              : (cx[j] - qtcc_pkg::SCALE_D);
        end
    end

    // Stage 2: overall winner, lowest index on a tie; reciprocal multiply.
    always_comb
    begin
        m01  = s1_w01_reg ? s1_abs_reg[1] : s1_abs_reg[0];
        m23  = s1_w23_reg ? s1_abs_reg[3] : s1_abs_reg[2];
        best = (m23 > m01) ? {1'b1, s1_w23_reg} : {1'b0, s1_w01_reg};
        case (best)
            2'd0:    s2_flip_next = s1_neg_reg[0];
            2'd1:    s2_flip_next = s1_neg_reg[1];
            2'd2:    s2_flip_next = s1_neg_reg[2];
            2'd3:    s2_flip_next = s1_neg_reg[3];
            default: s2_flip_next = 1'b0;
        endcase
        s2_idx_next = (s1_action_reg == qtcc_pkg::ACT_UNPACK) ? s1_idx_reg : best;
        for (int j = 0; j < 3; j++)
        begin
            s2_dprod_next[j] = qtcc_pkg::DPROD_W'(s1_dmag_reg[j]) * qtcc_pkg::RK_C;
        end
    end

    // Stage 3: pick the kept components and scale them; saturate unpacked values.
    always_comb
    begin
        sel_abs[0] = (s2_idx_reg == 2'd0) ? s2_abs_reg[1] : s2_abs_reg[0];
        sel_neg[0] = (s2_idx_reg == 2'd0) ? s2_neg_reg[1] : s2_neg_reg[0];
        sel_abs[1] = (s2_idx_reg <= 2'd1) ? s2_abs_reg[2] : s2_abs_reg[1];
        sel_neg[1] = (s2_idx_reg <= 2'd1) ? s2_neg_reg[2] : s2_neg_reg[1];
        sel_abs[2] = (s2_idx_reg <= 2'd2) ? s2_abs_reg[3] : s2_abs_reg[2];
        sel_neg[2] = (s2_idx_reg <= 2'd2) ? s2_neg_reg[3] : s2_neg_reg[2];
        for (int k = 0; k < 3; k++)
        begin
            s3_qprod_next[k] = qtcc_pkg::QPROD_W'(sel_abs[k]) * qtcc_pkg::SCALE_Q;
            s3_qneg_next[k]  = sel_neg[k] ^ s2_flip_reg;
            rx[k]  = qtcc_pkg::RX_W'(s2_dprod_reg[k][qtcc_pkg::DPROD_W-1:qtcc_pkg::RS]);
            lim[k] = s2_dneg_reg[k] ? qtcc_pkg::SAT_NEG_X : qtcc_pkg::SAT_POS_X;
            rc[k]  = (rx[k] > lim[k]) ? lim[k] : rx[k];
            rt[k]  = s2_dneg_reg[k] ? (~rc[k] + 1'b1) : rc[k];
            s3_kept_next[k] = rt[k][qtcc_pkg::COMP_W-1:0];
        end
    end

    // Stage 4: truncate, clamp and offset the codes; square the kept values.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            qs[k]   = s3_qprod_reg[k] >> qtcc_pkg::FRAC_BITS;
            qc[k]   = (qs[k] > qtcc_pkg::SCALE_Q) ? qtcc_pkg::SCALE_Q : qs[k];
            csum[k] = s3_qneg_reg[k] ? (qtcc_pkg::SCALE_C - qtcc_pkg::CSUM_W'(qc[k]))
                                     : (qtcc_pkg::SCALE_C + qtcc_pkg::CSUM_W'(qc[k]));
            s4_code_next[k] = csum[k][qtcc_pkg::CODE_W-1:0];
            kext[k] = {s3_kept_reg[k][qtcc_pkg::COMP_W-1], s3_kept_reg[k]};
            ka[k]   = kext[k][qtcc_pkg::ABS_W-1] ? (~kext[k] + 1'b1) : kext[k];
            s4_sq_next[k] = qtcc_pkg::SQ_W'(ka[k]) * qtcc_pkg::SQ_W'(ka[k]);
        end
    end

    // Stage 5 and 6: sum of squares, then the radicand clamped at zero.
    always_comb
    begin
        s5_sum_next = qtcc_pkg::SUM_W'(s4_sq_reg[0]) + qtcc_pkg::SUM_W'(s4_sq_reg[1])
                    + qtcc_pkg::SUM_W'(s4_sq_reg[2]);
        sumx = qtcc_pkg::DC_W'(s5_sum_reg);
        s6_diff_next = (qtcc_pkg::ONE_C > sumx) ?
                       qtcc_pkg::RAD_W'(qtcc_pkg::ONE_C - sumx) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_action_reg <= action;
            s1_idx_reg    <= drop_index;
            s1_neg_reg    <= s1_neg_next;
            s1_w01_reg    <= s1_w01_next;
            s1_w23_reg    <= s1_w23_next;
            s1_dneg_reg   <= s1_dneg_next;
            for (int i = 0; i < 4; i++)
            begin
                s1_abs_reg[i] <= s1_abs_next[i];
            end
            for (int j = 0; j < 3; j++)
            begin
                s1_dmag_reg[j] <= s1_dmag_next[j];
            end
        end
        if (adv[1])
        begin
            s2_action_reg <= s1_action_reg;
            s2_idx_reg    <= s2_idx_next;
            s2_neg_reg    <= s1_neg_reg;
            s2_flip_reg   <= s2_flip_next;
            s2_dneg_reg   <= s1_dneg_reg;
            for (int i = 0; i < 4; i++)
            begin
                s2_abs_reg[i] <= s1_abs_reg[i];
            end
            for (int j = 0; j < 3; j++)
            begin
                s2_dprod_reg[j] <= s2_dprod_next[j];
            end
        end
        if (adv[2])
        begin
            s3_action_reg <= s2_action_reg;
            s3_idx_reg    <= s2_idx_reg;
            s3_qneg_reg   <= s3_qneg_next;
            for (int k = 0; k < 3; k++)
            begin
                s3_qprod_reg[k] <= s3_qprod_next[k];
                s3_kept_reg[k]  <= s3_kept_next[k];
            end
        end
        if (adv[3])
        begin
            s4_action_reg <= s3_action_reg;
            s4_idx_reg    <= s3_idx_reg;
            for (int k = 0; k < 3; k++)
            begin
                s4_code_reg[k] <= s4_code_next[k];
                s4_kept_reg[k] <= s3_kept_reg[k];
                s4_sq_reg[k]   <= s4_sq_next[k];
            end
        end
        if (adv[4])
        begin
            s5_action_reg <= s4_action_reg;
            s5_idx_reg    <= s4_idx_reg;
            s5_sum_reg    <= s5_sum_next;
            for (int k = 0; k < 3; k++)
            begin
                s5_code_reg[k] <= s4_code_reg[k];
                s5_kept_reg[k] <= s4_kept_reg[k];
            end
        end
        if (adv[5])
        begin
            s6_action_reg <= s5_action_reg;
            s6_idx_reg    <= s5_idx_reg;
            s6_diff_reg   <= s6_diff_next;
            for (int k = 0; k < 3; k++)
            begin
                s6_code_reg[k] <= s5_code_reg[k];
                s6_kept_reg[k] <= s5_kept_reg[k];
            end
        end
    end

    always_comb
    begin
        out_data.item.action     = s6_action_reg;
        out_data.item.code_a     = s6_code_reg[0];
        out_data.item.code_b     = s6_code_reg[1];
        out_data.item.code_c     = s6_code_reg[2];
        out_data.item.drop_index = s6_idx_reg;
        out_data.item.kept_a     = s6_kept_reg[0];
        out_data.item.kept_b     = s6_kept_reg[1];
        out_data.item.kept_c     = s6_kept_reg[2];
        out_data.sq.rem          = '0;
        out_data.sq.root         = '0;
        out_data.sq.rad          = {1'b0, s6_diff_reg};
    end

endmodule

`default_nettype wire

[sv/qtcc_sqrt_cell.sv]
// One cell of the square-root row: resolves one root bit per transaction and
// passes the partial root, remainder and the rest of the transaction onward.
// Depends on qtcc_pkg.
`default_nettype none

module qtcc_sqrt_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire qtcc_pkg::cell_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output qtcc_pkg::cell_t      out_data
);

    logic                       valid_reg;
    qtcc_pkg::cell_t            data_reg;
    qtcc_pkg::cell_t            data_next;
    logic [qtcc_pkg::REM_W-1:0] cur;
    logic [qtcc_pkg::REM_W-1:0] trial;

    // Bring down the next two radicand bits and try a one in the next root bit.
    always_comb
    begin
        data_next = in_data;
        cur   = {in_data.sq.rem[qtcc_pkg::REM_W-3:0],
                 in_data.sq.rad[qtcc_pkg::RADP_W-1 -: 2]};
        trial = {in_data.sq.root, 2'b01};
        if (cur >= trial)
        begin
            data_next.sq.rem  = cur - trial;
            data_next.sq.root = {in_data.sq.root[qtcc_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            data_next.sq.rem  = cur;
            data_next.sq.root = {in_data.sq.root[qtcc_pkg::ROOT_W-2:0], 1'b0};
        end
        data_next.sq.rad = {in_data.sq.rad[qtcc_pkg::RADP_W-3:0], 2'b00};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[sv/quaternion_three_component_codec.sv]
// Top level of the smallest-three quaternion codec.
// Instantiates qtcc_prep and the row of qtcc_sqrt_cell; depends on qtcc_pkg.
//
// Usage: one input channel (in_valid/in_stall) carries a transaction with
// action and either four Q1.14 components (pack) or three codes and a drop
// index (unpack). The output channel (out_valid/out_stall) returns exactly one
// result transaction per input, in order. Pack results carry the three codes
// and the dropped index with the rebuilt components at zero; unpack results
// carry the four rebuilt components with the codes and index at zero.
// Throughput is one transaction per cycle while out_stall is low. Each
// transaction passes through six front stages, one cell per root bit
// (FRAC_BITS + 1 cells, fifteen here), and one output register. The root
// bits are resolved one per cell, which sets the depth. When out_stall is
// high the result is held and the pipeline keeps taking transactions until
// all 22 stages are occupied; only then is in_stall raised. Reset empties
// every stage; no result is pending after reset.
`default_nettype none

module quaternion_three_component_codec (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 action,
    input  wire logic signed [qtcc_pkg::COMP_W-1:0]   quat_x,
    input  wire logic signed [qtcc_pkg::COMP_W-1:0]   quat_y,
    input  wire logic signed [qtcc_pkg::COMP_W-1:0]   quat_z,
    input  wire logic signed [qtcc_pkg::COMP_W-1:0]   quat_w,
    input  wire logic        [qtcc_pkg::CODE_W-1:0]   code_a,
    input  wire logic        [qtcc_pkg::CODE_W-1:0]   code_b,
    input  wire logic        [qtcc_pkg::CODE_W-1:0]   code_c,
    input  wire logic        [qtcc_pkg::IDX_W-1:0]    drop_index,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic             [qtcc_pkg::CODE_W-1:0]   out_code_a,
    output logic             [qtcc_pkg::CODE_W-1:0]   out_code_b,
    output logic             [qtcc_pkg::CODE_W-1:0]   out_code_c,
    output logic             [qtcc_pkg::IDX_W-1:0]    out_drop_index,
    output logic signed      [qtcc_pkg::COMP_W-1:0]   rec_x,
    output logic signed      [qtcc_pkg::COMP_W-1:0]   rec_y,
    output logic signed      [qtcc_pkg::COMP_W-1:0]   rec_z,
    output logic signed      [qtcc_pkg::COMP_W-1:0]   rec_w
);

    logic [qtcc_pkg::NCELL:0] cell_valid;
    logic [qtcc_pkg::NCELL:0] cell_ready;
    qtcc_pkg::cell_t          cell_data [qtcc_pkg::NCELL+1];

    logic                        out_adv;
    logic                        out_valid_reg;
    qtcc_pkg::item_t             last_item;
    logic [qtcc_pkg::RC_W-1:0]   root_x;
    logic [qtcc_pkg::RC_W-1:0]   root_c;
    logic [qtcc_pkg::COMP_W-1:0] root_d;
    logic                        unpack;

    logic [qtcc_pkg::CODE_W-1:0] code_next [3];
    logic [qtcc_pkg::IDX_W-1:0]  idx_next;
    logic [qtcc_pkg::COMP_W-1:0] rec_next  [4];
    logic [qtcc_pkg::CODE_W-1:0] code_reg  [3];
    logic [qtcc_pkg::IDX_W-1:0]  idx_reg;
    logic [qtcc_pkg::COMP_W-1:0] rec_reg   [4];

    qtcc_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .quat_x     (quat_x),
        .quat_y     (quat_y),
        .quat_z     (quat_z),
        .quat_w     (quat_w),
        .code_a     (code_a),
        .code_b     (code_b),
        .code_c     (code_c),
        .drop_index (drop_index),
        .out_valid  (cell_valid[0]),
        .out_ready  (cell_ready[0]),
        .out_data   (cell_data[0])
    );

    for (genvar g = 0; g < qtcc_pkg::NCELL; g++)
    begin : g_cell
        qtcc_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cell_valid[g]),
            .in_ready  (cell_ready[g]),
            .in_data   (cell_data[g]),
            .out_valid (cell_valid[g+1]),
            .out_ready (cell_ready[g+1]),
            .out_data  (cell_data[g+1])
        );
    end

    assign out_adv                     = !out_valid_reg || !out_stall;
    assign cell_ready[qtcc_pkg::NCELL] = out_adv;

    // Place the rebuilt component at the dropped position.
    always_comb
    begin
        last_item = cell_data[qtcc_pkg::NCELL].item;
        unpack    = (last_item.action == qtcc_pkg::ACT_UNPACK);
        root_x    = qtcc_pkg::RC_W'(cell_data[qtcc_pkg::NCELL].sq.root);
        root_c    = (root_x > qtcc_pkg::SAT_R) ? qtcc_pkg::SAT_R : root_x;
        root_d    = root_c[qtcc_pkg::COMP_W-1:0];
        if (unpack)
        begin
            code_next[0] = '0;
            code_next[1] = '0;
            code_next[2] = '0;
            idx_next     = '0;
            rec_next[0]  = (last_item.drop_index == 2'd0) ? root_d : last_item.kept_a;
            rec_next[1]  = (last_item.drop_index == 2'd0) ? last_item.kept_a :
                           (last_item.drop_index == 2'd1) ? root_d : last_item.kept_b;
            rec_next[2]  = (last_item.drop_index <= 2'd1) ? last_item.kept_b :
                           (last_item.drop_index == 2'd2) ? root_d : last_item.kept_c;
            rec_next[3]  = (last_item.drop_index == 2'd3) ? root_d : last_item.kept_c;
        end
        else
        begin
            code_next[0] = last_item.code_a;
            code_next[1] = last_item.code_b;
            code_next[2] = last_item.code_c;
            idx_next     = last_item.drop_index;
            rec_next[0]  = '0;
            rec_next[1]  = '0;
            rec_next[2]  = '0;
            rec_next[3]  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= cell_valid[qtcc_pkg::NCELL];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            idx_reg <= idx_next;
            for (int k = 0; k < 3; k++)
            begin
                code_reg[k] <= code_next[k];
            end
            for (int i = 0; i < 4; i++)
            begin
                rec_reg[i] <= rec_next[i];
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_code_a     = code_reg[0];
    assign out_code_b     = code_reg[1];
    assign out_code_c     = code_reg[2];
    assign out_drop_index = idx_reg;
    assign rec_x          = $signed(rec_reg[0]);
    assign rec_y          = $signed(rec_reg[1]);
    assign rec_z          = $signed(rec_reg[2]);
    assign rec_w          = $signed(rec_reg[3]);

    // The input side only stalls when the whole pipeline is backed up.
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall)
    ) else $error("input stalled while the output register could move");

    // A result carries either pack fields or unpack fields, never both.
    a_mode_fields_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((rec_reg[0] == '0 && rec_reg[1] == '0 &&
                            rec_reg[2] == '0 && rec_reg[3] == '0) ||
                           (code_reg[0] == '0 && code_reg[1] == '0 &&
                            code_reg[2] == '0 && idx_reg == '0))
    ) else $error("result mixes pack and unpack fields");

    // The radicand never exceeds one, so the finished root never exceeds one.
    a_root_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        cell_valid[qtcc_pkg::NCELL] |->
            (cell_data[qtcc_pkg::NCELL].sq.root <= qtcc_pkg::ROOT_ONE)
    ) else $error("square-root row produced a root above one");

endmodule

`default_nettype wire
